[design/sha1_pkg.sv]
// Shared constants, codes and control types of the SHA-1 message digest block.
package sha1_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BLOCK_W    = 512;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_WORDS  = 5;

  localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
  localparam logic [POS_W-1:0]   POS_LENGTH = 6'd56;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
  localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;

  localparam logic [WORD_W-1:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  localparam logic [1:0] SEL_MSG  = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] push_sel;
    logic       count;
    logic       start;
    logic       round_step;
    logic       finish;
    logic       out_step;
    logic       restart;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last_round;
    logic             last_word;
  } status_t;

endpackage

[design/sha1_ctrl.sv]
// Controller state machine sequencing byte intake, padding, rounds and digest output.
module sha1_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  input  logic              s_tlast,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  sha1_pkg::status_t status,
  output sha1_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] ret;
  logic [2:0] ret_next;
  logic       block_full;

  assign block_full = (status.pos == sha1_pkg::POS_LAST);
  assign s_tready   = (state == S_IDLE);
  assign m_tvalid   = (state == S_OUT);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            cmd.push     = 1'b1;
            cmd.push_sel = sha1_pkg::SEL_MSG;
            cmd.count    = 1'b1;
            if (block_full) begin
              cmd.start  = 1'b1;
              ret_next   = s_tlast ? S_PAD : S_IDLE;
              state_next = S_ROUND;
            end else if (s_tlast) begin
              state_next = S_PAD;
            end
          end else if (s_tlast) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push     = 1'b1;
        cmd.push_sel = sha1_pkg::SEL_PAD;
        if (block_full) begin
          cmd.start  = 1'b1;
          ret_next   = S_ZERO;
          state_next = S_ROUND;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.push = 1'b1;
        if (status.pos == sha1_pkg::POS_LENGTH) begin
          cmd.push_sel = sha1_pkg::SEL_LEN;
          state_next   = S_LEN;
        end else begin
          cmd.push_sel = sha1_pkg::SEL_ZERO;
          if (block_full) begin
            cmd.start  = 1'b1;
            ret_next   = S_ZERO;
            state_next = S_ROUND;
          end
        end
      end
      S_LEN: begin
        cmd.push     = 1'b1;
        cmd.push_sel = sha1_pkg::SEL_LEN;
        if (block_full) begin
          cmd.start  = 1'b1;
          ret_next   = S_OUT;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.last_round) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = ret;
      end
      S_OUT: begin
        if (m_tready) begin
          cmd.out_step = 1'b1;
          if (status.last_word) begin
            cmd.restart = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

[design/sha1_dp.sv]
// Datapath with block shift register, round unit, chaining words and length counter.
module sha1_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  sha1_pkg::cmd_t                 cmd,
  input  logic [sha1_pkg::BYTE_W-1:0]    data_byte,
  output sha1_pkg::status_t              status,
  output logic [sha1_pkg::WORD_W-1:0]    digest_word,
  output logic [sha1_pkg::IDX_W-1:0]     word_number,
  output logic                           last_word
);

  logic [sha1_pkg::BLOCK_W-1:0] blk;
  logic [sha1_pkg::WORD_W-1:0]  h [sha1_pkg::NUM_WORDS];
  logic [sha1_pkg::WORD_W-1:0]  a, b, c, d, e;
  logic [63:0]                  bit_length;
  logic [sha1_pkg::POS_W-1:0]   pos;
  logic [sha1_pkg::ROUND_W-1:0] round;
  logic [sha1_pkg::IDX_W-1:0]   idx;

  logic [sha1_pkg::BYTE_W-1:0]  push_byte;
  logic [2:0]                   len_sel;
  logic [sha1_pkg::WORD_W-1:0]  w_cur;
  logic [sha1_pkg::WORD_W-1:0]  w_mix;
  logic [sha1_pkg::WORD_W-1:0]  w_new;
  logic [sha1_pkg::WORD_W-1:0]  f;
  logic [sha1_pkg::WORD_W-1:0]  k;
  logic [sha1_pkg::WORD_W-1:0]  t;

  assign len_sel = 3'd7 - pos[2:0];

  always_comb begin
    case (cmd.push_sel)
      sha1_pkg::SEL_MSG:  push_byte = data_byte;
      sha1_pkg::SEL_PAD:  push_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::SEL_ZERO: push_byte = '0;
      sha1_pkg::SEL_LEN:  push_byte = bit_length[{len_sel, 3'b000} +: 8];
      default:            push_byte = '0;
    endcase
  end

  assign w_cur = blk[511:480];
  assign w_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (round) inside
      [7'd0:7'd19]: begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end
      [7'd20:7'd39]: begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end
      [7'd40:7'd59]: begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w_cur;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_byte};
    end else if (cmd.round_step) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_step) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      round <= '0;
    end else if (cmd.round_step) begin
      round <= round + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
        h[i] <= sha1_pkg::IV[i];
      end
    end else if (cmd.finish) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      bit_length <= '0;
      pos        <= '0;
      idx        <= '0;
    end else begin
      if (cmd.count) begin
        bit_length <= bit_length + 64'd8;
      end
      if (cmd.push) begin
        pos <= pos + 6'd1;
      end
      if (cmd.out_step) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_comb begin
    case (idx)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      default: digest_word = h[4];
    endcase
  end

  assign word_number       = idx;
  assign last_word         = (idx == sha1_pkg::IDX_LAST);
  assign status.pos        = pos;
  assign status.last_round = (round == sha1_pkg::ROUND_LAST);
  assign status.last_word  = last_word;

endmodule

[design/sha1_message_digest.sv]
// Top level of the SHA-1 message digest block.
//
//   Channel | Direction | tdata               | tuser            | tlast
//   s_*     | in        | [7:0] data_byte     | [0] byte_present | message_end
//   m_*     | out       | [31:0] digest_word  | [2:0] word_number| last_word
//
// A message byte is taken while idle; the 64th byte of a block starts the 80 rounds
// of the shared round unit and then a chain update. A request with message_end
// runs padding, one or two blocks, at one byte per cycle outside the rounds, then
// offers five digest words on consecutive cycles if m_tready stays high.
// No request is taken while padding, rounds or digest output are in progress.
// Reset is synchronous; it loads the initial chaining words and clears the counters.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_number
  output logic        m_tlast
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;

  sha1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .status      (status),
    .digest_word (m_tdata),
    .word_number (m_tuser),
    .last_word   (m_tlast)
  );

endmodule

[design/sha1_checker.sv]
// Port-level assertions for the SHA-1 message digest block and their binding.
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,   // [31:0] digest_word
  input logic [2:0]  m_tuser,   // [2:0] word_number
  input logic        m_tlast
);

  // A waiting digest word must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("digest word changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready during digest output");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'd4)))
    else $error("last word flag does not match word number");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest words not in order");

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("request accepted during padding");

endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (.*);

[dv/tb_sha1_message_digest.sv]
// Self-checking testbench for the SHA-1 message digest block with an independent predictor.
`timescale 1ns / 100ps

module tb_sha1_message_digest;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 300;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] data_byte
  logic        s_tuser = 1'b0;   // [0] byte_present
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] digest_word
  logic [2:0]  m_tuser;          // [2:0] word_number
  logic        m_tlast;

  logic [31:0] w_sched [16];
  logic [31:0] h_chain [5];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  digest_word_t pending_words [$];
  int unsigned  mismatch_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_span = 0;
  int unsigned  cycle_count = 0;

  sha1_message_digest uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_round_block();
    logic [31:0] a, b, c, d, e, f, t;
    int slot;
    a = h_chain[0];
    b = h_chain[1];
    c = h_chain[2];
    d = h_chain[3];
    e = h_chain[4];
    for (int r = 0; r < 80; r++) begin
      slot = r & 15;
      if (r >= 16) begin
        w_sched[slot] = rol32(w_sched[(slot + 13) & 15] ^ w_sched[(slot + 8) & 15] ^
                              w_sched[(slot + 2) & 15] ^ w_sched[slot], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
      end else if (r < 40 || r >= 60) begin
        f = b ^ c ^ d;
      end else begin
        f = (b & c) | (b & d) | (c & d);
      end
      t = rol32(a, 5) + f + e + K_ROUND[r / 20] + w_sched[slot];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    h_chain[0] += a;
    h_chain[1] += b;
    h_chain[2] += c;
    h_chain[3] += d;
    h_chain[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    if (fill_pos[1:0] == 2'd0) begin
      w_sched[fill_pos[5:2]] = {24'h0, value};
    end else begin
      w_sched[fill_pos[5:2]] = {w_sched[fill_pos[5:2]][23:0], value};
    end
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) begin
      sha1_round_block();
    end
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 5; i++) h_chain[i] = H_INIT[i];
    msg_bits = 64'd0;
    fill_pos = 6'd0;
  endfunction

  function automatic void predict_request(input logic [7:0] value, input logic present,
                                          input logic ends);
    logic [63:0] length_bits;
    digest_word_t dw;
    if (present) begin
      absorb_byte(value);
      msg_bits += 64'd8;
    end
    if (!ends) return;
    length_bits = msg_bits;
    absorb_byte(PAD_MARK);
    while (fill_pos != LEN_SLOT) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(length_bits[8*i +: 8]);
    for (int i = 0; i < 5; i++) begin
      dw.word  = h_chain[i];
      dw.index = 3'(i);
      dw.last  = (i == 4);
      pending_words.insert(pending_words.size(), dw);
    end
    restart_digest();
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(64, 256);
    end
    stall_span--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        dw = pending_words.pop_front();
        if (m_tdata !== dw.word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, dw.word, m_tdata);
          mismatch_count++;
        end
        if (m_tuser !== dw.index) begin
          $display("%0t: word_number mismatch: expected %0d, actual %0d",
                   $time, dw.index, m_tuser);
          mismatch_count++;
        end
        if (m_tlast !== dw.last) begin
          $display("%0t: last_word mismatch: expected %0b, actual %0b",
                   $time, dw.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_request(input logic [7:0] value, input logic present, input logic ends);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= present;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(value, present, ends);
    if (present || ends) items_sent++;
    burst_left--;
  endtask

  task automatic send_message(input int unsigned len, input logic end_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 20);
    if (r < 90) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(66, 140);
  endfunction

  task automatic wait_for_digests();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(8'hA5, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned target);
    int unsigned start_count;
    start_count = items_sent;
    while (items_sent - start_count < target) begin
      send_message(pick_length(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_output_hold();
    hold_left = 2500;
    for (int i = 0; i < 3; i++) begin
      send_message($urandom_range(1, 10), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_drain_pause();
    send_message($urandom_range(0, 70), 1'($urandom_range(0, 1)));
    wait_for_digests();
    send_message($urandom_range(0, 70), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    restart_digest();
    test_directed();
    test_random_messages(RANDOM_ITEMS / 2);
    test_output_hold();
    test_drain_pause();
    test_random_messages(RANDOM_ITEMS / 2);
    wait_for_digests();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
